[rtl/core/rsf_pkg.sv]
package rsf_pkg;

  // Fixed field widths of the ports.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CHAN_W    = 8;
  localparam int HIST_W    = 24;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_MAX_HEIGHT     = 1024;
  localparam int DEF_BIN_COUNT_BITS = 24;

  // Register reset values (before clamping to the supported range).
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  // Operation codes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Luma weights in Q16 with a half-LSB rounding term.
  localparam int LUMA_SUM_W = 24;
  localparam int LUMA_WR    = 13933;
  localparam int LUMA_WG    = 46871;
  localparam int LUMA_WB    = 4732;
  localparam int LUMA_ROUND = 32768;

  // Histogram bin split points and bin codes.
  localparam logic [CHAN_W-1:0] LUMA_EDGE_LOW    = 8'd51;
  localparam logic [CHAN_W-1:0] LUMA_EDGE_MID    = 8'd102;
  localparam logic [CHAN_W-1:0] LUMA_EDGE_HIGH   = 8'd153;
  localparam logic [CHAN_W-1:0] LUMA_EDGE_BRIGHT = 8'd204;

  localparam int NUM_BINS = 5;
  localparam int BIN_SEL_W = 3;
  localparam logic [BIN_SEL_W-1:0] BIN_DARK   = 3'd0;
  localparam logic [BIN_SEL_W-1:0] BIN_LOW    = 3'd1;
  localparam logic [BIN_SEL_W-1:0] BIN_MID    = 3'd2;
  localparam logic [BIN_SEL_W-1:0] BIN_HIGH   = 3'd3;
  localparam logic [BIN_SEL_W-1:0] BIN_BRIGHT = 3'd4;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // One filtered pixel on its way to the histogram stage.
  typedef struct packed {
    pixel_t pix;
    logic   last_px;
  } result_t;

endpackage

[rtl/core/rsf_hist.sv]
module rsf_hist #(
  parameter int BIN_COUNT_BITS = rsf_pkg::DEF_BIN_COUNT_BITS
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 in_valid,
  output logic                                                 in_ready,
  input  rsf_pkg::result_t                                     in_res,
  output logic                                                 out_valid,
  input  logic                                                 out_ready,
  output rsf_pkg::result_t                                     out_res,
  output logic [rsf_pkg::NUM_BINS-1:0][rsf_pkg::HIST_W-1:0]   bin_cnt
);
  import rsf_pkg::*;

  logic                      s3_valid_r;
  result_t                   s3_res_r;
  logic [LUMA_SUM_W-1:0]     prod_red_r;
  logic [LUMA_SUM_W-1:0]     prod_grn_r;
  logic [LUMA_SUM_W-1:0]     prod_blu_r;
  logic                      out_valid_r;
  result_t                   out_res_r;
  logic [BIN_COUNT_BITS-1:0] bin_r [NUM_BINS];

  logic                      out_adv;
  logic                      s3_adv;
  logic                      load_out;
  logic [LUMA_SUM_W-1:0]     luma_sum;
  logic [CHAN_W-1:0]         luma;
  logic [BIN_SEL_W-1:0]      bin_sel;

  // Each stage moves on when its successor is empty or moving.
  assign out_adv  = !out_valid_r || out_ready;
  assign s3_adv   = !s3_valid_r || out_adv;
  assign in_ready = s3_adv;
  assign load_out = s3_valid_r && out_adv;

  // Product stage: the three weighted channels, one multiplier each.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_adv) begin
      s3_valid_r <= in_valid;
    end
    if (in_valid && s3_adv) begin
      s3_res_r   <= in_res;
      prod_red_r <= LUMA_SUM_W'(in_res.pix.red) * LUMA_SUM_W'(LUMA_WR);
      prod_grn_r <= LUMA_SUM_W'(in_res.pix.green) * LUMA_SUM_W'(LUMA_WG);
      prod_blu_r <= LUMA_SUM_W'(in_res.pix.blue) * LUMA_SUM_W'(LUMA_WB);
    end
  end

  // Rounded luma and its bin.
  always_comb begin
    luma_sum = prod_red_r + prod_grn_r + prod_blu_r + LUMA_SUM_W'(LUMA_ROUND);
    luma     = luma_sum[LUMA_SUM_W-1:LUMA_SUM_W-CHAN_W];
    if (luma < LUMA_EDGE_LOW) begin
      bin_sel = BIN_DARK;
    end else if (luma < LUMA_EDGE_MID) begin
      bin_sel = BIN_LOW;
    end else if (luma < LUMA_EDGE_HIGH) begin
      bin_sel = BIN_MID;
    end else if (luma < LUMA_EDGE_BRIGHT) begin
      bin_sel = BIN_HIGH;
    end else begin
      bin_sel = BIN_BRIGHT;
    end
  end

  // Output register; the bins always hold the counts as of the pixel it shows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_BINS; k++) begin
        bin_r[k] <= '0;
      end
    end else begin
      if (out_adv) begin
        out_valid_r <= s3_valid_r;
      end
      if (load_out) begin
        for (int k = 0; k < NUM_BINS; k++) begin
          if (bin_sel == BIN_SEL_W'(k) && bin_r[k] != '1) begin
            bin_r[k] <= bin_r[k] + BIN_COUNT_BITS'(1);
          end
        end
      end
    end
    if (load_out) begin
      out_res_r <= s3_res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    for (int k = 0; k < NUM_BINS; k++) begin
      bin_cnt[k] = HIST_W'(bin_r[k]);
    end
  end

endmodule

[rtl/core/rgb_sharpen_filter_with_histogram_top.sv]
// 3x3 Laplacian sharpen of an RGB raster stream with a five-bin luma histogram.
// Pixels (operation 0) enter in raster order; each produces the filtered pixel
// of the row above, so the first row gives no result. After the last pixel of
// the image, one drain item (operation 1) per column emits the stored last row,
// and the last of them carries final_pixel. Interior pixels become
// 5*center - N - S - W - E per channel, clamped; border pixels pass unchanged.
// The bin outputs hold the saturating counts including the pixel shown.
// Width and height are clamped to 3..MAX on write and should be changed
// between images. The block takes one item per clock unless out_ready holds the
// pipeline back: the center, north and east pixels come from two line memories,
// each read at two addresses and written at one in the accepting cycle, so
// there is no read/write conflict to stall on. A result is shown on the outputs
// after it passes four register stages (line-memory read, sharpen, luma
// products, and the bin update with the output register), the first of them
// loaded by the accepting edge. The line memories are not cleared after reset.
module rgb_sharpen_filter_with_histogram_top #(
  parameter int MAX_WIDTH      = rsf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = rsf_pkg::DEF_MAX_HEIGHT,
  parameter int BIN_COUNT_BITS = rsf_pkg::DEF_BIN_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_operation,
  input  logic [rsf_pkg::CHAN_W-1:0]     in_red_in,
  input  logic [rsf_pkg::CHAN_W-1:0]     in_green_in,
  input  logic [rsf_pkg::CHAN_W-1:0]     in_blue_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rsf_pkg::CHAN_W-1:0]     out_red_out,
  output logic [rsf_pkg::CHAN_W-1:0]     out_green_out,
  output logic [rsf_pkg::CHAN_W-1:0]     out_blue_out,
  output logic                           out_final_pixel,
  output logic [rsf_pkg::HIST_W-1:0]     out_bin_dark,
  output logic [rsf_pkg::HIST_W-1:0]     out_bin_low,
  output logic [rsf_pkg::HIST_W-1:0]     out_bin_mid,
  output logic [rsf_pkg::HIST_W-1:0]     out_bin_high,
  output logic [rsf_pkg::HIST_W-1:0]     out_bin_bright,
  input  logic                           cfg_we,
  input  logic [rsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsf_pkg::CFG_W-1:0]      cfg_wdata
);
  import rsf_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned x;
    x = 32'(v);
    if (x < 3) begin
      clamp_dim = 3;
    end else if (x > maxv) begin
      clamp_dim = maxv;
    end else begin
      clamp_dim = x;
    end
  endfunction

  // 5*c - n - s - w - e, clamped to one channel.
  function automatic logic [CHAN_W-1:0] sharpen_chan(
    input logic [CHAN_W-1:0] c, input logic [CHAN_W-1:0] n,
    input logic [CHAN_W-1:0] s, input logic [CHAN_W-1:0] w,
    input logic [CHAN_W-1:0] e);
    logic [11:0]        pos;
    logic [11:0]        neg;
    logic signed [12:0] diff;
    pos  = {2'b00, c, 2'b00} + {4'b0000, c};
    neg  = {4'b0000, n} + {4'b0000, s} + {4'b0000, w} + {4'b0000, e};
    diff = $signed({1'b0, pos}) - $signed({1'b0, neg});
    if (diff < 0) begin
      sharpen_chan = '0;
    end else if (diff > 13'sd255) begin
      sharpen_chan = '1;
    end else begin
      sharpen_chan = diff[CHAN_W-1:0];
    end
  endfunction

  // Configuration and position state.
  logic [WD_W-1:0]  w_r;
  logic [HT_W-1:0]  h_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             drain_r, drain_nxt;
  logic             sel_r, sel_nxt;

  // Line memories and their registered read data.
  pixel_t mem_a_r [MAX_WIDTH];
  pixel_t mem_b_r [MAX_WIDTH];
  pixel_t a_rd0_r, a_rd1_r, b_rd0_r, b_rd1_r;

  // Sharpen stage.
  logic    s1_valid_r, s1_sharp_r, s1_last_r, s1_is_pix_r, s1_sel_r;
  pixel_t  s1_south_r;
  pixel_t  west_r;
  logic    s2_valid_r;
  result_t s2_res_r;

  logic             in_fire, pix_act, drn_act, produce;
  logic [COL_W:0]   col_p1;
  logic [ROW_W:0]   row_p1;
  logic             row_end, img_end;
  logic [COL_W-1:0] col_east;
  pixel_t           pix_in;
  pixel_t           centre, north, east, sharp;
  logic             s1_adv, s2_adv;
  logic             hist_ready;
  result_t          out_res;
  logic [NUM_BINS-1:0][HIST_W-1:0] bin_cnt;

  // Configuration registers hold the clamped dimensions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WD_W'(clamp_dim(CFG_W'(RESET_WIDTH), MAX_WIDTH));
      h_r <= HT_W'(clamp_dim(CFG_W'(RESET_HEIGHT), MAX_HEIGHT));
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_WIDTH) begin
        w_r <= WD_W'(clamp_dim(cfg_wdata, MAX_WIDTH));
      end
      if (cfg_index == CFG_IDX_HEIGHT) begin
        h_r <= HT_W'(clamp_dim(cfg_wdata, MAX_HEIGHT));
      end
    end
  end

  // Item decode.
  assign s2_adv   = !s2_valid_r || hist_ready;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = rst_n && s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign pix_act  = in_fire && (in_operation == OP_PIXEL) && !drain_r;
  assign drn_act  = in_fire && (in_operation == OP_DRAIN) && drain_r;
  assign produce  = (pix_act && row_r != '0) || drn_act;
  assign pix_in   = '{red: in_red_in, green: in_green_in, blue: in_blue_in};

  assign col_p1   = {1'b0, col_r} + (COL_W+1)'(1);
  assign row_p1   = {1'b0, row_r} + (ROW_W+1)'(1);
  assign row_end  = col_p1 >= (COL_W+1)'(w_r);
  assign img_end  = row_p1 >= (ROW_W+1)'(h_r);
  assign col_east = (col_r == COL_W'(MAX_WIDTH - 1)) ? col_r : col_p1[COL_W-1:0];

  // Raster position, store swap at row end and drain mode.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    sel_nxt   = sel_r;
    if (pix_act) begin
      if (row_end) begin
        col_nxt = '0;
        sel_nxt = ~sel_r;
        if (img_end) begin
          row_nxt   = '0;
          drain_nxt = 1'b1;
        end else begin
          row_nxt = row_p1[ROW_W-1:0];
        end
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end else if (drn_act) begin
      if (row_end) begin
        col_nxt   = '0;
        drain_nxt = 1'b0;
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Line memory A: current row when the select is low, previous row otherwise.
  // Reads return the data from before the write in the same cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_rd0_r <= mem_a_r[col_r];
      a_rd1_r <= mem_a_r[col_east];
      if (pix_act && !sel_r) begin
        mem_a_r[col_r] <= pix_in;
      end
    end
  end

  // Line memory B, the mirror of A.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_rd0_r <= mem_b_r[col_r];
      b_rd1_r <= mem_b_r[col_east];
      if (pix_act && sel_r) begin
        mem_b_r[col_r] <= pix_in;
      end
    end
  end

  // Read stage control: what the fetched neighbors are for.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_fire && produce;
    end
    if (in_fire) begin
      s1_sharp_r  <= pix_act && row_r >= ROW_W'(2) && col_r != '0 && !row_end;
      s1_last_r   <= drn_act && row_end;
      s1_is_pix_r <= pix_act;
      s1_sel_r    <= sel_r;
      s1_south_r  <= pix_in;
    end
  end

  // Pick previous and two-back rows out of the two memories.
  always_comb begin
    centre = s1_sel_r ? a_rd0_r : b_rd0_r;
    east   = s1_sel_r ? a_rd1_r : b_rd1_r;
    north  = s1_sel_r ? b_rd0_r : a_rd0_r;
    sharp.red   = sharpen_chan(centre.red, north.red, s1_south_r.red,
                               west_r.red, east.red);
    sharp.green = sharpen_chan(centre.green, north.green, s1_south_r.green,
                               west_r.green, east.green);
    sharp.blue  = sharpen_chan(centre.blue, north.blue, s1_south_r.blue,
                               west_r.blue, east.blue);
  end

  // Sharpen result register; the west neighbor follows each pixel's center.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      west_r     <= '0;
    end else begin
      if (s2_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && s2_adv && s1_is_pix_r) begin
        west_r <= centre;
      end
    end
    if (s1_valid_r && s2_adv) begin
      s2_res_r.pix     <= s1_sharp_r ? sharp : centre;
      s2_res_r.last_px <= s1_last_r;
    end
  end

  rsf_hist #(
    .BIN_COUNT_BITS (BIN_COUNT_BITS)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_ready  (hist_ready),
    .in_res    (s2_res_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .bin_cnt   (bin_cnt)
  );

  assign out_red_out     = out_res.pix.red;
  assign out_green_out   = out_res.pix.green;
  assign out_blue_out    = out_res.pix.blue;
  assign out_final_pixel = out_res.last_px;
  assign out_bin_dark    = bin_cnt[BIN_DARK];
  assign out_bin_low     = bin_cnt[BIN_LOW];
  assign out_bin_mid     = bin_cnt[BIN_MID];
  assign out_bin_high    = bin_cnt[BIN_HIGH];
  assign out_bin_bright  = bin_cnt[BIN_BRIGHT];

  // Draining always starts and runs with the row counter back at zero.
  a_drain_row: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> row_r == '0)
    else $error("row position not zero while draining");

  // A sharpened pixel is never a drain item nor the final pixel.
  a_sharp_kind: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_sharp_r |-> s1_is_pix_r && !s1_last_r)
    else $error("sharpen applied to a drain item");

  // Input is held off only by a full read stage.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r)
    else $error("input stalled with an empty read stage");

  // The line stores swap only after the last pixel of a row.
  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(sel_r) |-> $past(pix_act && row_end))
    else $error("line store swap outside a row end");

endmodule
